// ===== hdl/bffz_pkg.sv =====
// Shared constants, types and helper functions of the bit map find-first-zero block.
package bffz_pkg;

	localparam int MAP_WORDS = 32;
	localparam int WORD_BITS = 32;
	localparam int WORD_AW   = $clog2(MAP_WORDS);
	localparam int BIT_AW    = $clog2(WORD_BITS);
	localparam int MODE_W    = 3;
	localparam int IDX_W     = 10;
	localparam int WIU_W     = 6;
	localparam int TDATA_W   = 16;

	typedef logic [MODE_W-1:0] mode_t;

	localparam mode_t MODE_TEST      = 3'd0;
	localparam mode_t MODE_SET       = 3'd1;
	localparam mode_t MODE_CLEAR_BIT = 3'd2;
	localparam mode_t MODE_CLEAR_ALL = 3'd3;
	localparam mode_t MODE_FILL_ALL  = 3'd4;
	localparam mode_t MODE_FIND      = 3'd5;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // capture a new request
		logic bit_rd;    // read the addressed word
		logic bit_upd;   // test or modify the addressed word
		logic sweep_wr;  // write the fill pattern to the counted word
		logic find_rd;   // read the counted word for the search
		logic res_load;  // capture the search result
		logic out_load;  // move the result into the output register
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic in_bit;     // incoming request is test, set or clear bit
		logic in_sweep;   // incoming request is clear all or fill all
		logic in_find;    // incoming request is find first zero
		logic cnt_last;   // word counter sits on the last word in use
		logic rd_act;     // search read data is present this cycle
		logic rd_hit;     // that word holds a zero bit
		logic rd_last;    // that word is the last word in use
		logic issue_more; // search reads remain to be issued
		logic out_free;   // output register can take a result
	} dp_stat_t;

	// Position of the first zero bit counted from the most significant bit.
	function automatic logic [BIT_AW-1:0] first_zero(input logic [WORD_BITS-1:0] w);
		logic [BIT_AW-1:0] pos;
		logic              hit;
		pos = '0;
		hit = 1'b0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (!hit && !w[WORD_BITS-1-i]) begin
				pos = BIT_AW'(i);
				hit = 1'b1;
			end
		end
		return pos;
	endfunction

endpackage

// ===== hdl/bffz_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
module bffz_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hdl/bffz_ctrl.sv =====
// Controller state machine that sequences each request through the datapath.
module bffz_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  bffz_pkg::dp_stat_t  stat,
	output bffz_pkg::dp_cmd_t   cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BIT_RD,
		ST_BIT_UPD,
		ST_SWEEP,
		ST_FIND,
		ST_DONE
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					if (stat.in_bit) begin
						state_nxt = ST_BIT_RD;
					end else if (stat.in_sweep) begin
						state_nxt = ST_SWEEP;
					end else if (stat.in_find) begin
						state_nxt = ST_FIND;
					end else begin
						state_nxt = ST_DONE;
					end
				end
			end
			ST_BIT_RD: begin
				cmd.bit_rd = 1'b1;
				state_nxt  = ST_BIT_UPD;
			end
			ST_BIT_UPD: begin
				cmd.bit_upd = 1'b1;
				state_nxt   = ST_DONE;
			end
			ST_SWEEP: begin
				cmd.sweep_wr = 1'b1;
				if (stat.cnt_last) begin
					state_nxt = ST_DONE;
				end
			end
			ST_FIND: begin
				// Reads are pipelined: the word checked now was issued last cycle.
				if (stat.rd_act && (stat.rd_hit || stat.rd_last)) begin
					cmd.res_load = 1'b1;
					state_nxt    = ST_DONE;
				end else if (stat.issue_more) begin
					cmd.find_rd = 1'b1;
				end
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign s_tready = (state_q == ST_IDLE);

endmodule

// ===== hdl/bffz_dp.sv =====
// Datapath: configuration register, map storage, word counter, search logic and output register.
module bffz_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [bffz_pkg::WIU_W-1:0]        cfg_wr_data,
	input  logic [bffz_pkg::TDATA_W-1:0]      s_tdata,
	input  bffz_pkg::dp_cmd_t                 cmd,
	output bffz_pkg::dp_stat_t                stat,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [bffz_pkg::TDATA_W-1:0]      m_tdata
);

	localparam int WA = bffz_pkg::WORD_AW;
	localparam int BA = bffz_pkg::BIT_AW;
	localparam int WB = bffz_pkg::WORD_BITS;

	logic [bffz_pkg::WIU_W-1:0]   wiu_q;
	logic [bffz_pkg::WIU_W-1:0]   wiu_m1;
	logic [WA-1:0]                words_m1;
	bffz_pkg::mode_t              in_mode;
	logic [bffz_pkg::IDX_W-1:0]   in_idx;
	logic [bffz_pkg::IDX_W-1:0]   sat_idx;

	bffz_pkg::mode_t              mode_q;
	logic [WA-1:0]                word_q;
	logic [BA-1:0]                pos_q;
	logic [WA-1:0]                cnt_q;
	logic                         issued_last_q;
	logic [bffz_pkg::MAP_WORDS-1:0] vld_q;

	logic                         rd_act_s1;
	logic                         rd_last_s1;
	logic [WA-1:0]                rd_word_s1;
	logic                         rd_vld_s1;

	logic                         res_bit_q;
	logic [bffz_pkg::IDX_W-1:0]   res_idx_q;
	logic                         res_nf_q;
	logic                         out_vld_q;
	logic [bffz_pkg::TDATA_W-1:0] out_data_q;

	logic                         ram_we;
	logic [WA-1:0]                ram_waddr;
	logic [WB-1:0]                ram_wdata;
	logic                         ram_re;
	logic [WA-1:0]                ram_raddr;
	logic [WB-1:0]                ram_rdata;
	logic [WB-1:0]                word_eff;
	logic [WB-1:0]                mask;
	logic                         cnt_last;

	// Words in use, with zero acting as one and large values clamped to the map.
	assign wiu_m1 = wiu_q - bffz_pkg::WIU_W'(1);
	always_comb begin
		if (wiu_q == '0) begin
			words_m1 = '0;
		end else if (wiu_q > bffz_pkg::WIU_W'(bffz_pkg::MAP_WORDS)) begin
			words_m1 = WA'(bffz_pkg::MAP_WORDS - 1);
		end else begin
			words_m1 = wiu_m1[WA-1:0];
		end
	end

	assign in_mode = s_tdata[bffz_pkg::MODE_W-1:0];
	assign in_idx  = s_tdata[bffz_pkg::MODE_W +: bffz_pkg::IDX_W];

	// An index past the last bit in use saturates to that bit.
	always_comb begin
		if (in_idx[BA +: WA] > words_m1) begin
			sat_idx = {words_m1, {BA{1'b1}}};
		end else begin
			sat_idx = in_idx;
		end
	end

	assign stat.in_bit   = (in_mode == bffz_pkg::MODE_TEST) ||
	                       (in_mode == bffz_pkg::MODE_SET) ||
	                       (in_mode == bffz_pkg::MODE_CLEAR_BIT);
	assign stat.in_sweep = (in_mode == bffz_pkg::MODE_CLEAR_ALL) ||
	                       (in_mode == bffz_pkg::MODE_FILL_ALL);
	assign stat.in_find  = (in_mode == bffz_pkg::MODE_FIND);

	assign cnt_last        = (cnt_q == words_m1);
	assign stat.cnt_last   = cnt_last;
	assign stat.rd_act     = rd_act_s1;
	assign stat.rd_hit     = (word_eff != '1);
	assign stat.rd_last    = rd_last_s1;
	assign stat.issue_more = !issued_last_q;
	assign stat.out_free   = !out_vld_q || m_tready;

	// A word never written since reset reads as zero.
	assign word_eff = rd_vld_s1 ? ram_rdata : '0;
	// Bit 0 of a word is its most significant bit, so shift by the inverted position.
	assign mask     = WB'(1) << (~pos_q);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cnt_q;
		ram_wdata = (mode_q == bffz_pkg::MODE_FILL_ALL) ? '1 : '0;
		if (cmd.sweep_wr) begin
			ram_we = 1'b1;
		end else if (cmd.bit_upd && ((mode_q == bffz_pkg::MODE_SET) ||
		                             (mode_q == bffz_pkg::MODE_CLEAR_BIT))) begin
			ram_we    = 1'b1;
			ram_waddr = word_q;
			ram_wdata = (mode_q == bffz_pkg::MODE_SET) ? (word_eff | mask) : (word_eff & ~mask);
		end
	end

	assign ram_re    = cmd.bit_rd || cmd.find_rd;
	assign ram_raddr = cmd.bit_rd ? word_q : cnt_q;

	bffz_ram #(
		.WIDTH (WB),
		.DEPTH (bffz_pkg::MAP_WORDS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wiu_q         <= bffz_pkg::WIU_W'(32);
			vld_q         <= '0;
			rd_act_s1     <= 1'b0;
			issued_last_q <= 1'b0;
			out_vld_q     <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				wiu_q <= cfg_wr_data;
			end
			if (ram_we) begin
				vld_q[ram_waddr] <= 1'b1;
			end
			rd_act_s1 <= cmd.find_rd;
			if (cmd.load) begin
				issued_last_q <= 1'b0;
			end else if (cmd.find_rd && cnt_last) begin
				issued_last_q <= 1'b1;
			end
			if (cmd.out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q    <= in_mode;
			word_q    <= sat_idx[BA +: WA];
			pos_q     <= sat_idx[BA-1:0];
			cnt_q     <= '0;
			res_bit_q <= 1'b0;
			res_idx_q <= '0;
			res_nf_q  <= 1'b0;
		end else begin
			if ((cmd.sweep_wr || cmd.find_rd) && !cnt_last) begin
				cnt_q <= cnt_q + WA'(1);
			end
			if (cmd.bit_upd && (mode_q == bffz_pkg::MODE_TEST)) begin
				res_bit_q <= |(word_eff & mask);
			end
			if (cmd.res_load) begin
				if (stat.rd_hit) begin
					res_idx_q <= bffz_pkg::IDX_W'({rd_word_s1, bffz_pkg::first_zero(word_eff)});
					res_nf_q  <= 1'b0;
				end else begin
					res_idx_q <= '0;
					res_nf_q  <= 1'b1;
				end
			end
		end
		if (ram_re) begin
			rd_vld_s1  <= vld_q[ram_raddr];
			rd_word_s1 <= ram_raddr;
			rd_last_s1 <= cnt_last;
		end
		if (cmd.out_load) begin
			out_data_q <= bffz_pkg::TDATA_W'({res_nf_q, res_idx_q, res_bit_q});
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

endmodule

// ===== hdl/bitmap_find_first_zero.sv =====
// Top level of the bit map find-first-zero block: controller plus datapath.
//
// Requests arrive one beat at a time on the slave stream (s_tvalid, s_tready,
// s_tdata) and each produces exactly one result beat on the master stream
// (m_tvalid, m_tready, m_tdata). The request picks a mode: test, set or clear
// one bit, clear or fill all words in use, or find the lowest zero bit.
// The number of words in use is written through cfg_wr_en and cfg_wr_data;
// the user must write it only while the block is idle, which the block itself
// does not enforce. It resets to the full map of 32 words. Work is done one
// request at a time. For test, set and clear the word is read through the
// RAM's registered read port and, for set and clear, written back.
// Clear all and fill all write one word per cycle.
// Find reads one word per cycle and stops at the first word holding a zero or
// at the last word in use. The next request can be accepted from the cycle in
// which the result is presented.
// After reset the map reads as all zeros: a valid bit per word marks the words
// written since then, so no clearing pass is needed.
// The result sits in an output register; if the receiver stalls, the block
// finishes the next request and then waits until the register is taken.
module bitmap_find_first_zero (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [bffz_pkg::WIU_W-1:0]        cfg_wr_data, // words_in_use
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [bffz_pkg::TDATA_W-1:0]      s_tdata,     // mode[2:0], bit_index[12:3], zero fill
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [bffz_pkg::TDATA_W-1:0]      m_tdata      // bit_value[0], found_index[10:1],
	                                                       // not_found[11], zero fill
);

	bffz_pkg::dp_cmd_t  cmd;
	bffz_pkg::dp_stat_t stat;

	// The controller steps through the phases of each request.
	bffz_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// The datapath holds the map, the counter and the result registers.
	bffz_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tdata     (s_tdata),
		.cmd         (cmd),
		.stat        (stat),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

endmodule

// ===== tb/bffz_result_checker.sv =====
// Result checker for the bit map find-first-zero block: map predictor and in-order comparison.
`timescale 1ns / 100ps

module bffz_result_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [bffz_pkg::WIU_W-1:0]   cfg_wr_data,
	input  logic                         s_tvalid,
	input  logic                         s_tready,
	input  logic [bffz_pkg::TDATA_W-1:0] s_tdata,
	input  logic                         m_tvalid,
	input  logic                         m_tready,
	input  logic [bffz_pkg::TDATA_W-1:0] m_tdata,
	output int                           fail_count,
	output int                           pending,
	output int                           results_seen,
	output int                           finds_missed
);

	// Result beat fields from the lowest bit up: bit_value, found_index, not_found.
	typedef struct packed {
		logic                       not_found;
		logic [bffz_pkg::IDX_W-1:0] found_index;
		logic                       bit_value;
	} map_result_t;

	logic [bffz_pkg::WORD_BITS-1:0] map_mem [bffz_pkg::MAP_WORDS];
	logic [bffz_pkg::WIU_W-1:0]     map_size;
	map_result_t                    result_q [$];
	map_result_t                    want;
	map_result_t                    got;
	int                             fails;
	int                             seen;
	int                             missed;

	// Applies one request to the model map and returns the result it produces.
	function automatic map_result_t apply_request(input bffz_pkg::mode_t mode,
		input logic [bffz_pkg::IDX_W-1:0] idx_in);
		map_result_t                    r;
		int                             words;
		int                             last;
		int                             idx;
		int                             w;
		logic [bffz_pkg::WORD_BITS-1:0] pattern;
		logic                           hit;
		r     = '0;
		words = map_size;
		if (words == 0)
			words = 1;
		if (words > bffz_pkg::MAP_WORDS)
			words = bffz_pkg::MAP_WORDS;
		last = words * bffz_pkg::WORD_BITS - 1;
		idx  = idx_in;
		if (idx > last)
			idx = last;
		w = idx / bffz_pkg::WORD_BITS;
		case (mode)
			bffz_pkg::MODE_TEST: begin
				r.bit_value = map_mem[w][bffz_pkg::WORD_BITS-1-(idx % bffz_pkg::WORD_BITS)];
			end
			bffz_pkg::MODE_SET: begin
				map_mem[w][bffz_pkg::WORD_BITS-1-(idx % bffz_pkg::WORD_BITS)] = 1'b1;
			end
			bffz_pkg::MODE_CLEAR_BIT: begin
				map_mem[w][bffz_pkg::WORD_BITS-1-(idx % bffz_pkg::WORD_BITS)] = 1'b0;
			end
			bffz_pkg::MODE_CLEAR_ALL, bffz_pkg::MODE_FILL_ALL: begin
				pattern = (mode == bffz_pkg::MODE_FILL_ALL) ? '1 : '0;
				for (int k = 0; k < words; k++)
					map_mem[k] = pattern;
			end
			bffz_pkg::MODE_FIND: begin
				hit = 1'b0;
				for (int k = 0; k < words; k++) begin
					for (int p = 0; p < bffz_pkg::WORD_BITS; p++) begin
						if (!hit && !map_mem[k][bffz_pkg::WORD_BITS-1-p]) begin
							r.found_index = bffz_pkg::IDX_W'(k * bffz_pkg::WORD_BITS + p);
							hit           = 1'b1;
						end
					end
				end
				r.not_found = !hit;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < bffz_pkg::MAP_WORDS; k++)
				map_mem[k] = '0;
			map_size = bffz_pkg::WIU_W'(bffz_pkg::MAP_WORDS);
			result_q.delete();
			fails        = 0;
			seen         = 0;
			missed       = 0;
			fail_count   <= 0;
			pending      <= 0;
			results_seen <= 0;
			finds_missed <= 0;
		end else begin
			if (cfg_wr_en)
				map_size = cfg_wr_data;
			if (s_tvalid && s_tready)
				result_q.push_back(apply_request(
					bffz_pkg::mode_t'(s_tdata[bffz_pkg::MODE_W-1:0]),
					s_tdata[bffz_pkg::MODE_W +: bffz_pkg::IDX_W]));
			if (m_tvalid && m_tready) begin
				got  = m_tdata[$bits(map_result_t)-1:0];
				seen = seen + 1;
				if (got.not_found)
					missed = missed + 1;
				if (result_q.size() == 0) begin
					$error("result beat arrived with no request outstanding");
					fails = fails + 1;
				end else begin
					want = result_q.pop_front();
					if (got.bit_value !== want.bit_value) begin
						$error("bit_value: expected %0d, actual %0d", want.bit_value, got.bit_value);
						fails = fails + 1;
					end
					if (got.found_index !== want.found_index) begin
						$error("found_index: expected %0d, actual %0d",
							want.found_index, got.found_index);
						fails = fails + 1;
					end
					if (got.not_found !== want.not_found) begin
						$error("not_found: expected %0d, actual %0d", want.not_found, got.not_found);
						fails = fails + 1;
					end
				end
			end
			pending      <= result_q.size();
			fail_count   <= fails;
			results_seen <= seen;
			finds_missed <= missed;
		end
	end

endmodule

// ===== tb/tb_top.sv =====
// Top of the bit map find-first-zero testbench: clock, reset, stimulus, idling and verdict.
`timescale 1ns / 100ps

module tb_top;

	// The two mode codes the block answers with an all-zero result and no change.
	localparam bffz_pkg::mode_t MODE_SPARE_LO = 3'd6;
	localparam bffz_pkg::mode_t MODE_SPARE_HI = 3'd7;

	// Cycles without any accepted beat on either stream before the run is declared hung.
	// The longest legal quiet stretch is the receiver hold-off.
	localparam int STALL_LIMIT = 5000;
	// Cycles allowed after the last result for any straggling beat to show up.
	localparam int TAIL_CYCLES = 40;

	logic                         clk         = 1'b0;
	logic                         arst_n      = 1'b0;
	logic                         cfg_wr_en   = 1'b0;
	logic [bffz_pkg::WIU_W-1:0]   cfg_wr_data = '0;
	logic                         s_tvalid    = 1'b0;
	logic                         s_tready;
	logic [bffz_pkg::TDATA_W-1:0] s_tdata     = '0;    // mode[2:0], bit_index[12:3], zero fill
	logic                         m_tvalid;
	logic                         m_tready    = 1'b0;
	logic [bffz_pkg::TDATA_W-1:0] m_tdata;     // bit_value[0], found_index[10:1], not_found[11]

	int fail_count;
	int pending;
	int results_seen;
	int finds_missed;

	int req_sent    = 0;
	int size_writes = 0;
	int cur_words   = bffz_pkg::MAP_WORDS;  // effective map size, used only to steer indices
	bit tx_steady   = 1'b0;       // when set, the sender offers back-to-back beats
	int idle_cycles = 0;
	int rx_count    = 0;
	int next_hold   = 150;        // result count at which the receiver holds off

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	bitmap_find_first_zero i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

	bffz_result_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.fail_count  (fail_count),
		.pending     (pending),
		.results_seen(results_seen),
		.finds_missed(finds_missed)
	);

	// Sender gap before a beat: mostly none or a short one, now and then a long one.
	function automatic int tx_gap();
		int roll;
		if (tx_steady)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 4);
		return $urandom_range(10, 40);
	endfunction

	// Mostly an index inside the words in use; one time in ten anything the field allows,
	// which exercises the saturation to the last bit in use.
	function automatic logic [bffz_pkg::IDX_W-1:0] pick_index();
		if ($urandom_range(0, 9) == 0)
			return bffz_pkg::IDX_W'($urandom_range(0, 1023));
		return bffz_pkg::IDX_W'($urandom_range(0, cur_words * bffz_pkg::WORD_BITS - 1));
	endfunction

	// Offers one request beat and returns at the edge where it is accepted. The valid
	// is dropped only when a gap is taken, so it is never lowered and raised in one step.
	task automatic send(input bffz_pkg::mode_t mode, input logic [bffz_pkg::IDX_W-1:0] idx);
		int gap;
		gap = tx_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			s_tdata  <= bffz_pkg::TDATA_W'($urandom);
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= bffz_pkg::TDATA_W'({idx, mode});
		do @(posedge clk); while (!s_tready);
		req_sent++;
	endtask

	// Stops offering and waits until every outstanding result has been taken. Every
	// request yields a result, so the block is idle once the checker has none pending.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Rewrites the words-in-use register while the block is idle.
	task automatic set_words(input int value);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= bffz_pkg::WIU_W'(value);
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		cur_words   = (value == 0) ? 1 :
			((value > bffz_pkg::MAP_WORDS) ? bffz_pkg::MAP_WORDS : value);
		size_writes++;
	endtask

	// Random traffic, built mostly from short sequences that leave a known hole pattern
	// in the map before a find, so that searches land on every word and bit position.
	task automatic run_random(input int n);
		int              done;
		int              holes;
		int              run_len;
		int              roll;
		bffz_pkg::mode_t mode;
		done = 0;
		while (done < n) begin
			tx_steady = ($urandom_range(0, 5) == 0);
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					// A single request with a mode mix tilted toward the bit operations.
					roll = $urandom_range(0, 99);
					if (roll < 25)
						mode = bffz_pkg::MODE_TEST;
					else if (roll < 45)
						mode = bffz_pkg::MODE_SET;
					else if (roll < 60)
						mode = bffz_pkg::MODE_CLEAR_BIT;
					else if (roll < 85)
						mode = bffz_pkg::MODE_FIND;
					else if (roll < 90)
						mode = bffz_pkg::MODE_CLEAR_ALL;
					else if (roll < 95)
						mode = bffz_pkg::MODE_FILL_ALL;
					else
						mode = ($urandom_range(0, 1) != 0) ? MODE_SPARE_HI : MODE_SPARE_LO;
					send(mode, pick_index());
					done += 1;
				end
				4, 5, 6: begin
					// Full map with up to two holes punched into it, then a search and a test.
					send(bffz_pkg::MODE_FILL_ALL, pick_index());
					holes = $urandom_range(0, 2);
					repeat (holes) send(bffz_pkg::MODE_CLEAR_BIT, pick_index());
					send(bffz_pkg::MODE_FIND, pick_index());
					send(bffz_pkg::MODE_TEST, pick_index());
					done += holes + 3;
				end
				7, 8: begin
					// Empty map with a short run of ones from bit 0, then a search.
					send(bffz_pkg::MODE_CLEAR_ALL, pick_index());
					run_len = $urandom_range(1, 5);
					for (int b = 0; b < run_len; b++)
						send(bffz_pkg::MODE_SET, bffz_pkg::IDX_W'(b));
					send(bffz_pkg::MODE_FIND, pick_index());
					done += run_len + 2;
				end
				default: begin
					// Unused mode codes or a test, at unrestricted indices with arbitrary content.
					mode = bffz_pkg::mode_t'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
					if ($urandom_range(0, 1) != 0)
						mode = bffz_pkg::MODE_TEST;
					send(mode, bffz_pkg::IDX_W'($urandom_range(0, 1023)));
					done += 1;
				end
			endcase
		end
		tx_steady = 1'b0;
	endtask

	// Count of taken results, used by the receiver to time its long hold-off.
	always @(posedge clk)
		if (m_tvalid && m_tready)
			rx_count <= rx_count + 1;

	// Receiver: stretches of ready with random stalls between them. Twice in the run it
	// holds off while the sender keeps offering, so the
	// output register fills and the block pushes back on its input.
	initial begin
		int run;
		int gap;
		int roll;
		wait (arst_n);
		@(posedge clk);
		forever begin
			run  = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
			roll = $urandom_range(0, 99);
			if (roll < 50)
				gap = 0;
			else if (roll < 90)
				gap = $urandom_range(1, 3);
			else
				gap = $urandom_range(8, 30);
			if (rx_count >= next_hold) begin
				gap       = 400;
				next_hold = (next_hold < 450) ? 450 : 32'h7fff_ffff;
			end
			m_tready <= 1'b1;
			repeat (run) @(posedge clk);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	// Watchdog: a long stretch with no beat accepted on either stream means a hang.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("bitmap_find_first_zero regression: fail");
				$finish;
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part on the full 32-word map left by reset.
		send(bffz_pkg::MODE_FIND, '0);             // empty map: lowest zero is bit 0
		send(bffz_pkg::MODE_TEST, '0);
		send(bffz_pkg::MODE_SET, '0);
		send(bffz_pkg::MODE_SET, 10'd1023);        // last bit of the last word
		send(bffz_pkg::MODE_TEST, 10'd1023);
		send(bffz_pkg::MODE_TEST, '0);
		send(bffz_pkg::MODE_FIND, '0);             // bit 0 is taken, expect 1
		send(bffz_pkg::MODE_CLEAR_BIT, '0);
		send(bffz_pkg::MODE_FIND, 10'd1023);
		send(bffz_pkg::MODE_FILL_ALL, '0);
		send(bffz_pkg::MODE_FIND, '0);             // no zero anywhere
		send(bffz_pkg::MODE_TEST, 10'd512);
		send(bffz_pkg::MODE_CLEAR_BIT, 10'd777);
		send(bffz_pkg::MODE_FIND, '0);             // the single hole in the middle
		send(bffz_pkg::MODE_CLEAR_ALL, 10'd1023);
		send(bffz_pkg::MODE_TEST, 10'd1023);
		send(MODE_SPARE_LO, 10'd1023);
		send(MODE_SPARE_HI, 10'd1023);

		// One word in use: indices saturate to bit 31, and sweeps stay in word 0.
		set_words(1);
		send(bffz_pkg::MODE_SET, 10'd1023);
		send(bffz_pkg::MODE_TEST, 10'd31);
		send(bffz_pkg::MODE_FILL_ALL, '0);
		send(bffz_pkg::MODE_FIND, '0);
		set_words(bffz_pkg::MAP_WORDS);
		send(bffz_pkg::MODE_TEST, 10'd32);         // word 1 was outside the fill and stays clear
		send(bffz_pkg::MODE_FIND, '0);

		// Random phases over several map sizes, extremes and out-of-range codes first.
		set_words(0);
		run_random(70);
		set_words(63);
		run_random(80);
		set_words(1);
		run_random(70);
		set_words(33);
		run_random(80);
		set_words(2);
		run_random(80);
		for (int ph = 0; ph < 3; ph++) begin
			set_words($urandom_range(0, 63));
			run_random(80);
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d requests over %0d words-in-use settings;", req_sent, size_writes);
		$display("%0d results compared, %0d of them searches with no zero found.",
			results_seen, finds_missed);
		if (fail_count == 0 && pending == 0) begin
			$display("bitmap_find_first_zero regression: pass");
		end else begin
			$display("bitmap_find_first_zero regression: fail");
		end
		$finish;
	end

endmodule
